// ===== design/pn2d_pkg.sv =====
// Shared constants, register codes and corner-gradient helpers for the 2D gradient noise block.
package pn2d_pkg;

    localparam int TABLE_DEPTH = 512;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
    localparam int FRAC_BITS   = 16;

    localparam logic [31:0] XW_WORD = 32'h24552A2F;
    localparam logic [31:0] YW_WORD = 32'h1222A301;

    localparam logic [15:0] SCALE_RECIP_RESET = 16'd4096;
    localparam logic [3:0]  OCTAVE_RESET      = 4'd0;

    localparam logic signed [39:0] OUT_MAX = 40'sd67108863;
    localparam logic signed [39:0] OUT_MIN = -40'sd67108864;

    typedef enum logic {
        CFG_OCTAVE_SHIFT = 1'b0,
        CFG_SCALE_RECIP  = 1'b1
    } cfg_index_t;

    // Weighted offset for a two-bit weight field coding -1, 0, 1 or 2.
    function automatic logic signed [19:0] weight_term(logic [1:0] f, logic signed [17:0] d);
        logic signed [19:0] dw;
        dw = 20'(d);
        case (f)
            2'd0:    return -dw;
            2'd1:    return 20'sd0;
            2'd2:    return dw;
            default: return dw <<< 1;
        endcase
    endfunction

    function automatic logic signed [19:0] corner(logic [7:0] hash, logic signed [17:0] dx,
                                                  logic signed [17:0] dy);
        logic [3:0]  h;
        logic [31:0] xs;
        logic [31:0] ys;
        h  = hash[3:0];
        xs = XW_WORD >> h;
        ys = YW_WORD >> h;
        return weight_term(xs[1:0], dx) + weight_term(ys[1:0], dy);
    endfunction

endpackage

// ===== design/pn2d_req_if.sv =====
// Request channel carrying table loads and noise evaluations.
interface pn2d_req_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [8:0]         table_index;
    logic [7:0]         table_value;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;

    modport source (output valid, kind, table_index, table_value, coord_x, coord_y,
                    input ready);
    modport sink   (input valid, kind, table_index, table_value, coord_x, coord_y,
                    output ready);
endinterface

// ===== design/pn2d_rsp_if.sv =====
// Response channel carrying noise results.
interface pn2d_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [26:0] noise_value;

    modport source (output valid, noise_value, input ready);
    modport sink   (input valid, noise_value, output ready);
endinterface

// ===== design/pn2d_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pn2d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/perlin_noise_2d.sv =====
// Top level of the pipelined 2D gradient noise generator.
//
//  Channel | Direction | Contents
//  req     | in        | kind, table_index, table_value, coord_x, coord_y
//  rsp     | out       | noise_value
//  cfg     | in        | cfg_we, cfg_index, cfg_wdata
//
// A request enters every cycle unless held back; evaluates pass v1..v7 to out_v_reg.
// The three dependent table lookups run in ten replicated 512x8 RAM copies, one per read.
// A load request waits while an evaluate is in the three table-read stages.
// A stall at the response freezes the whole pipeline, RAM reads included.
// Reset clears valid bits and presets cfg registers; the table is undefined until loaded.
module perlin_noise_2d (
    input  logic        clk,
    input  logic        rst_n,
    pn2d_req_if.sink    req,
    pn2d_rsp_if.source  rsp,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);

    logic [3:0]  octave_reg;
    logic [15:0] scale_reg;

    logic adv;
    logic load_acc;
    logic eval_acc;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, out_v_reg;

    logic signed [32:0] px, py;

    logic [15:0] tx1_reg, ty1_reg, tx2_reg, ty2_reg, tx3_reg, ty3_reg, tx4_reg, ty4_reg;
    logic [7:0]  cx1_reg, cy1_reg, cy2_reg;

    logic [15:0]        t2x_reg, t2y_reg, t3x_reg, t3y_reg;
    logic signed [20:0] qx_reg, qy_reg;
    logic signed [21:0] px3_reg, py3_reg;
    logic signed [17:0] u4_reg, v4f_reg, u5_reg, v5f_reg, v6f_reg;

    logic signed [19:0] g11_reg, g12_reg, g21_reg, g22_reg;
    logic signed [21:0] c1_reg, c2_reg;
    logic signed [22:0] r_reg;
    logic signed [26:0] noise_reg;

    logic [8:0] l1_addr [2];
    logic [7:0] l1_data [2];
    logic [8:0] l2_addr [4];
    logic [7:0] l2_data [4];
    logic [8:0] l3_addr [4];
    logic [7:0] l3_data [4];

    logic [31:0]        sq_x, sq_y, cu_x, cu_y;
    logic signed [20:0] q_x, q_y;
    logic signed [37:0] tq_x, tq_y;
    logic signed [38:0] f_x, f_y;
    logic signed [17:0] dx0, dx1, dy0, dy1;
    logic signed [20:0] d1, d2;
    logic signed [38:0] m1, m2;
    logic signed [22:0] d3;
    logic signed [40:0] m3;
    logic signed [39:0] shifted;
    logic signed [26:0] sat;

    assign adv      = !out_v_reg || rsp.ready;
    assign req.ready = adv && !(!req.kind && (v1_reg || v2_reg || v3_reg));
    assign load_acc = req.valid && req.ready && !req.kind;
    assign eval_acc = req.valid && req.ready && req.kind;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octave_reg <= pn2d_pkg::OCTAVE_RESET;
            scale_reg  <= pn2d_pkg::SCALE_RECIP_RESET;
        end
        else if (cfg_we)
        begin
            case (pn2d_pkg::cfg_index_t'(cfg_index))
                pn2d_pkg::CFG_OCTAVE_SHIFT: octave_reg <= cfg_wdata[3:0];
                pn2d_pkg::CFG_SCALE_RECIP:  scale_reg  <= cfg_wdata;
                default:                    scale_reg  <= scale_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0; v4_reg <= 1'b0;
            v5_reg <= 1'b0; v6_reg <= 1'b0; v7_reg <= 1'b0; out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= eval_acc; v2_reg <= v1_reg; v3_reg <= v2_reg; v4_reg <= v3_reg;
            v5_reg <= v4_reg; v6_reg <= v5_reg; v7_reg <= v6_reg; out_v_reg <= v7_reg;
        end
    end

    // Stage 0: scale the coordinates into Q16.16.
    assign px = 33'(req.coord_x) * $signed({17'd0, scale_reg});
    assign py = 33'(req.coord_y) * $signed({17'd0, scale_reg});

    // Stage 2 fade terms.
    assign sq_x = 32'(tx1_reg) * 32'(tx1_reg);
    assign sq_y = 32'(ty1_reg) * 32'(ty1_reg);
    assign q_x  = $signed({5'd0, tx1_reg}) * 21'sd6 - 21'sd983040;
    assign q_y  = $signed({5'd0, ty1_reg}) * 21'sd6 - 21'sd983040;

    // Stage 3 fade terms.
    assign cu_x = 32'(t2x_reg) * 32'(tx2_reg);
    assign cu_y = 32'(t2y_reg) * 32'(ty2_reg);
    assign tq_x = 38'($signed({1'b0, tx2_reg})) * 38'(qx_reg);
    assign tq_y = 38'($signed({1'b0, ty2_reg})) * 38'(qy_reg);

    // Stage 4 fade result.
    assign f_x = 39'($signed({1'b0, t3x_reg})) * 39'(px3_reg);
    assign f_y = 39'($signed({1'b0, t3y_reg})) * 39'(py3_reg);

    assign dx0 = $signed({2'b00, tx4_reg});
    assign dy0 = $signed({2'b00, ty4_reg});
    assign dx1 = dx0 - 18'sd65536;
    assign dy1 = dy0 - 18'sd65536;

    // Interpolation.
    assign d1 = 21'(g12_reg) - 21'(g11_reg);
    assign d2 = 21'(g22_reg) - 21'(g21_reg);
    assign m1 = 39'(u5_reg) * 39'(d1);
    assign m2 = 39'(u5_reg) * 39'(d2);
    assign d3 = 23'(c2_reg) - 23'(c1_reg);
    assign m3 = 41'(v6f_reg) * 41'(d3);

    assign shifted = 40'(r_reg) <<< octave_reg;
    always_comb
    begin
        if (shifted > pn2d_pkg::OUT_MAX)
        begin
            sat = pn2d_pkg::OUT_MAX[26:0];
        end
        else if (shifted < pn2d_pkg::OUT_MIN)
        begin
            sat = pn2d_pkg::OUT_MIN[26:0];
        end
        else
        begin
            sat = shifted[26:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tx1_reg <= px[15:0];  ty1_reg <= py[15:0];
            cx1_reg <= px[23:16]; cy1_reg <= py[23:16];

            tx2_reg <= tx1_reg; ty2_reg <= ty1_reg; cy2_reg <= cy1_reg;
            t2x_reg <= sq_x[31:16]; t2y_reg <= sq_y[31:16];
            qx_reg  <= q_x; qy_reg <= q_y;

            tx3_reg <= tx2_reg; ty3_reg <= ty2_reg;
            t3x_reg <= cu_x[31:16]; t3y_reg <= cu_y[31:16];
            px3_reg <= 22'(tq_x >>> 16) + 22'sd655360;
            py3_reg <= 22'(tq_y >>> 16) + 22'sd655360;

            tx4_reg <= tx3_reg; ty4_reg <= ty3_reg;
            u4_reg  <= 18'(f_x >>> 16);
            v4f_reg <= 18'(f_y >>> 16);

            g11_reg <= pn2d_pkg::corner(l3_data[0], dx0, dy0);
            g21_reg <= pn2d_pkg::corner(l3_data[1], dx0, dy1);
            g12_reg <= pn2d_pkg::corner(l3_data[2], dx1, dy0);
            g22_reg <= pn2d_pkg::corner(l3_data[3], dx1, dy1);
            u5_reg  <= u4_reg; v5f_reg <= v4f_reg;

            c1_reg  <= 22'(g11_reg) + 22'(m1 >>> 16);
            c2_reg  <= 22'(g21_reg) + 22'(m2 >>> 16);
            v6f_reg <= v5f_reg;

            r_reg <= 23'(c1_reg) + 23'(m3 >>> 16);

            noise_reg <= sat;
        end
    end

    // Table lookup addresses for the three dependent levels.
    always_comb
    begin
        l1_addr[0] = {1'b0, cx1_reg};
        l1_addr[1] = {1'b0, cx1_reg} + 9'd1;
        l2_addr[0] = {1'b0, l1_data[0]} + {1'b0, cy2_reg};
        l2_addr[1] = l2_addr[0] + 9'd1;
        l2_addr[2] = {1'b0, l1_data[1]} + {1'b0, cy2_reg};
        l2_addr[3] = l2_addr[2] + 9'd1;
        for (int k = 0; k < 4; k++)
        begin
            l3_addr[k] = {1'b0, l2_data[k]};
        end
    end

    for (genvar i = 0; i < 2; i++)
    begin : g_l1
        pn2d_ram #(.WIDTH(8), .DEPTH(pn2d_pkg::TABLE_DEPTH)) u_ram (
            .clk(clk), .we(load_acc), .waddr(req.table_index), .wdata(req.table_value),
            .re(adv), .raddr(l1_addr[i]), .rdata(l1_data[i])
        );
    end

    for (genvar i = 0; i < 4; i++)
    begin : g_l23
        pn2d_ram #(.WIDTH(8), .DEPTH(pn2d_pkg::TABLE_DEPTH)) u_ram2 (
            .clk(clk), .we(load_acc), .waddr(req.table_index), .wdata(req.table_value),
            .re(adv), .raddr(l2_addr[i]), .rdata(l2_data[i])
        );
        pn2d_ram #(.WIDTH(8), .DEPTH(pn2d_pkg::TABLE_DEPTH)) u_ram3 (
            .clk(clk), .we(load_acc), .waddr(req.table_index), .wdata(req.table_value),
            .re(adv), .raddr(l3_addr[i]), .rdata(l3_data[i])
        );
    end

    assign rsp.valid       = out_v_reg;
    assign rsp.noise_value = noise_reg;

    a_load_no_reader: assert property (@(posedge clk) disable iff (!rst_n)
        load_acc |-> !(v1_reg || v2_reg || v3_reg))
        else $error("table load while an evaluate is reading the table");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> (v7_reg == $past(v7_reg)) && (v1_reg == $past(v1_reg)))
        else $error("pipeline moved during a stall");

    a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_v_reg) |-> $past(v7_reg))
        else $error("result appeared without a pipeline item");

    a_ready_needs_adv: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> adv)
        else $error("request accepted while the pipeline is stalled");

endmodule

// ===== tb/sv/perlin_noise_2d_chk.sv =====
// Checker for the 2D gradient noise block: predicts each result and compares it.
module perlin_noise_2d_chk
    import pn2d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    pn2d_req_if         req,
    pn2d_rsp_if         rsp,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    output int          fail_count,
    output int          pending
);

    logic [7:0]         perm_copy [TABLE_DEPTH];
    logic [3:0]         octave_q;
    logic [15:0]        scale_q;
    logic signed [26:0] noise_fifo [$];

    function automatic longint fx_mul(longint a, longint b);
        return (a * b) >>> FRAC_BITS;
    endfunction

    function automatic longint fade_q(longint t);
        longint t2;
        longint t3;
        longint p;
        t2 = fx_mul(t, t);
        t3 = fx_mul(t2, t);
        p  = fx_mul(t, 6 * t - 15 * 65536) + 10 * 65536;
        return fx_mul(t3, p);
    endfunction

    function automatic int perm_at(int i);
        return int'(perm_copy[i % TABLE_DEPTH]);
    endfunction

    function automatic longint grad_dot(int hash, longint dx, longint dy);
        logic [3:0]  h;
        logic [31:0] xs;
        logic [31:0] ys;
        h  = hash[3:0];
        xs = XW_WORD >> h;
        ys = YW_WORD >> h;
        return (longint'(xs[1:0]) - 1) * dx + (longint'(ys[1:0]) - 1) * dy;
    endfunction

    function automatic longint lerp_q(longint a, longint b, longint w);
        return a + fx_mul(w, b - a);
    endfunction

    function automatic logic signed [26:0] noise_at(logic signed [15:0] x,
                                                     logic signed [15:0] y);
        longint px;
        longint py;
        longint tx;
        longint ty;
        longint u;
        longint v;
        longint c1;
        longint c2;
        longint r;
        int     cx;
        int     cy;
        int     xi;
        int     yi;
        px = longint'(x) * longint'({48'd0, scale_q});
        py = longint'(y) * longint'({48'd0, scale_q});
        cx = int'(px[23:16]);
        cy = int'(py[23:16]);
        tx = px & 64'hFFFF;
        ty = py & 64'hFFFF;
        u  = fade_q(tx);
        v  = fade_q(ty);
        xi = perm_at(cx) + cy;
        yi = perm_at(cx + 1) + cy;
        c1 = lerp_q(grad_dot(perm_at(perm_at(xi)), tx, ty),
                    grad_dot(perm_at(perm_at(yi)), tx - 65536, ty), u);
        c2 = lerp_q(grad_dot(perm_at(perm_at(xi + 1)), tx, ty - 65536),
                    grad_dot(perm_at(perm_at(yi + 1)), tx - 65536, ty - 65536), u);
        r  = lerp_q(c1, c2, v) <<< octave_q;
        if (r > 64'sd67108863)
            r = 64'sd67108863;
        if (r < -64'sd67108864)
            r = -64'sd67108864;
        return r[26:0];
    endfunction

    initial
    begin
        fail_count = 0;
        pending    = 0;
        foreach (perm_copy[i])
            perm_copy[i] = 8'd0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octave_q <= OCTAVE_RESET;
            scale_q  <= SCALE_RECIP_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_OCTAVE_SHIFT)
                octave_q <= cfg_wdata[3:0];
            else
                scale_q <= cfg_wdata;
        end
    end

    always @(posedge clk)
    begin
        logic signed [26:0] want;
        if (rst_n && req.valid && req.ready)
        begin
            if (req.kind == 1'b0)
                perm_copy[req.table_index] = req.table_value;
            else
                noise_fifo.push_back(noise_at(req.coord_x, req.coord_y));
        end
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (noise_fifo.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: noise_value %0d", rsp.noise_value);
            end
            else
            begin
                want = noise_fifo.pop_front();
                if (want !== rsp.noise_value)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("noise_value mismatch: expected %0d, got %0d",
                                 want, rsp.noise_value);
                end
            end
        end
        pending = noise_fifo.size();
    end

endmodule

// ===== tb/sv/perlin_noise_2d_tb.sv =====
// Testbench top for the 2D gradient noise block: stimulus, stalls and verdict.
module perlin_noise_2d_tb;
    import pn2d_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_wdata;
    int          fail_count;
    int          pending;
    bit          long_hold;
    int          burst_left;

    pn2d_req_if req ();
    pn2d_rsp_if rsp ();

    perlin_noise_2d u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    perlin_noise_2d_chk u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiver alternates ready and randomly stalled stretches, or long_hold stalls.
    initial
    begin
        int  stretch;
        bit  stalling;
        rsp.ready = 1'b0;
        stretch   = 0;
        stalling  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                rsp.ready <= 1'b0;
                repeat (300) @(negedge clk);
                long_hold = 1'b0;
            end
            else
            begin
                if (stretch == 0)
                begin
                    stretch  = $urandom_range(10, 60);
                    stalling = ~stalling;
                end
                stretch--;
                rsp.ready <= stalling ? ($urandom_range(0, 9) < 6) : 1'b1;
            end
        end
    end

    // Called at a falling edge; returns at one after acceptance and any burst gap.
    task automatic send_request(logic kind, logic [8:0] idx, logic [7:0] val,
                                logic signed [15:0] x, logic signed [15:0] y);
        req.valid       <= 1'b1;
        req.kind        <= kind;
        req.table_index <= idx;
        req.table_value <= val;
        req.coord_x     <= x;
        req.coord_y     <= y;
        do
            @(posedge clk);
        while (!req.ready);
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        else
            burst_left--;
    endtask

    task automatic send_eval(logic signed [15:0] x, logic signed [15:0] y);
        send_request(1'b1, 9'($urandom), 8'($urandom), x, y);
    endtask

    task automatic send_random_eval();
        logic signed [15:0] x;
        logic signed [15:0] y;
        if ($urandom_range(0, 3) == 0)
        begin
            x = 16'($signed($urandom_range(0, 40)) - 20);
            y = 16'($signed($urandom_range(0, 40)) - 20);
        end
        else
        begin
            x = 16'($urandom);
            y = 16'($urandom);
        end
        send_eval(x, y);
    endtask

    task automatic send_random_load();
        send_request(1'b0, 9'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        wait (pending == 0);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        logic [3:0]  octaves [6];
        logic [15:0] scales  [6];
        req.valid       = 1'b0;
        req.kind        = 1'b0;
        req.table_index = '0;
        req.table_value = '0;
        req.coord_x     = '0;
        req.coord_y     = '0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_OCTAVE_SHIFT;
        cfg_wdata       = '0;
        long_hold       = 1'b0;
        burst_left      = 8;
        octaves = '{4'd0, 4'd8, 4'd3, 4'd0, 4'd15, 4'd1};
        scales  = '{16'd4096, 16'd65535, 16'd1, 16'd0, 16'd40000, 16'd777};
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // The whole table is loaded before any sample can read it.
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_request(1'b0, 9'(i), (i == 0) ? 8'd255 : 8'($urandom), 16'($urandom),
                         16'($urandom));

        // Reset settings first, with the coordinate extremes.
        send_eval(16'sh8000, 16'sh8000);
        send_eval(16'sh7FFF, 16'sh7FFF);
        send_eval(16'sh8000, 16'sh7FFF);
        send_eval(16'sh0000, 16'sh0000);
        send_eval(-16'sd1, 16'sd1);
        send_request(1'b0, 9'h1FF, 8'hFF, 16'sh7FFF, 16'sh8000);
        send_request(1'b0, 9'h000, 8'h00, 16'sh0000, 16'sh0000);
        send_eval(16'sd15, -16'sd17);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            write_reg(CFG_OCTAVE_SHIFT, {12'd0, octaves[phase]});
            write_reg(CFG_SCALE_RECIP, scales[phase]);
            send_eval(16'sh8000, 16'sh7FFF);
            send_eval(16'sh7FFF, 16'sh8000);
            send_eval(16'sd1, 16'sd1);
            if (phase == 1)
                long_hold = 1'b1;
            for (int n = 0; n < 17; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_random_load();
                else
                    send_random_eval();
            end
            drain();
        end

        wait (pending == 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/pn2d_pkg.sv
design/pn2d_req_if.sv
design/pn2d_rsp_if.sv
design/pn2d_ram.sv
design/perlin_noise_2d.sv
tb/sv/perlin_noise_2d_chk.sv
tb/sv/perlin_noise_2d_tb.sv
